// ----- hdl/assert_macros.svh -----
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define AHDLC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion label failed");

// condition that must never be seen at a clock edge out of reset
`define AHDLC_NEVER(label, clk, rst_n, cond) \
  `AHDLC_ASSERT(label, clk, rst_n, !(cond))

`endif

// ----- hdl/ahdlc_pkg.sv -----
// types, constants and the fcs-16 byte update of the hdlc receive deframer
package ahdlc_pkg;

  // control octets of the async hdlc framing
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // fcs-16 constants
  localparam logic [15:0] FCS_INIT = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD = 16'hF0B8;
  localparam logic [15:0] FCS_POLY = 16'h8408;

  // width of the limit register and of the reported length
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned LEN_SAT = 2047;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_e;

  // reflected fcs-16 update over one byte
  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

endpackage

// ----- hdl/async_hdlc_receive_deframer_unit.sv -----
// async hdlc receive deframer: flag hunt, unescape, fcs-16 check, fcs strip
//
// Input channel: one raw link byte per beat on rx_byte_i (in_valid_i / in_stall_o).
// Output channel: one result per beat (out_valid_o / out_stall_i): kind_o says
// payload byte, good frame end (frame_len_o = payload bytes), bad frame end
// (fcs residue wrong, fewer than two bytes, or escape followed by flag) or
// overflow abort. Payload bytes come out two bytes late, so the two fcs
// bytes of a frame are never shown. Bytes while hunting, escapes, flags that
// close an empty frame and the first two bytes of a frame produce no result.
// A result is registered: it shows on the outputs from the clock edge at which
// the byte that causes it is taken. Throughput: one byte per cycle while the
// output does not stall, with a byte-wide fcs update and one result register.
// Stall: while a result waits in the output register and the receiver
// stalls, in_stall_o is high; otherwise a byte is taken every cycle it is offered.
// Reset: the block hunts for a flag, the length limit is 2048 and the
// output register is empty. cfg_we_i writes the limit; write it only idle.
module async_hdlc_receive_deframer_unit #(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [ahdlc_pkg::CFG_W-1:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 data_o,
  output logic [ahdlc_pkg::LEN_W-1:0] frame_len_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned LIM_W = (CNT_W > ahdlc_pkg::CFG_W) ? CNT_W : ahdlc_pkg::CFG_W;
  localparam int unsigned LW    = (CNT_W > ahdlc_pkg::LEN_W) ? CNT_W : ahdlc_pkg::LEN_W;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_e;

  mode_e                      mode_q, mode_d;
  logic [15:0]                fcs_q, fcs_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [1:0]                 hcnt_q, hcnt_d;
  logic [7:0]                 held0_q, held0_d, held1_q, held1_d;
  logic [ahdlc_pkg::CFG_W-1:0] limit_cfg_q;

  logic                       res_valid_q;
  ahdlc_pkg::kind_e           res_kind_q, kind_d;
  logic [7:0]                 res_data_q, data_d;
  logic [ahdlc_pkg::LEN_W-1:0] res_len_q, len_d;
  logic                       emit;

  logic                       in_take;
  logic [LIM_W-1:0]           limit;
  logic                       over;
  logic [7:0]                 ubyte;
  logic [LW-1:0]              len_full;

  // take a byte whenever the result register is free or drains this cycle
  assign in_stall_o = res_valid_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;

  // effective limit, capped at MAX_FRAME
  assign limit = (LIM_W'(limit_cfg_q) > LIM_W'(MAX_FRAME)) ? LIM_W'(MAX_FRAME)
                                                            : LIM_W'(limit_cfg_q);
  assign over  = LIM_W'(cnt_q) >= limit;
  assign ubyte = (mode_q == MODE_ESC) ? (rx_byte_i ^ ahdlc_pkg::ESC_XOR) : rx_byte_i;

  // payload length without the fcs; saturated where it is reported
  assign len_full = LW'(cnt_q) - LW'(2);

  // per-beat framing logic
  always_comb begin
    mode_d  = mode_q;
    fcs_d   = fcs_q;
    cnt_d   = cnt_q;
    hcnt_d  = hcnt_q;
    held0_d = held0_q;
    held1_d = held1_q;
    emit    = 1'b0;
    kind_d  = ahdlc_pkg::KIND_PAYLOAD;
    data_d  = 8'h00;
    len_d   = '0;
    case (mode_q)
      MODE_HUNT: begin
        if (rx_byte_i == ahdlc_pkg::FLAG_BYTE) begin
          mode_d = MODE_FRAME;
          fcs_d  = ahdlc_pkg::FCS_INIT;
          cnt_d  = '0;
          hcnt_d = '0;
        end
      end
      MODE_FRAME, MODE_ESC: begin
        if (mode_q == MODE_FRAME && rx_byte_i == ahdlc_pkg::ESC_BYTE) begin
          mode_d = MODE_ESC;
        end else if (rx_byte_i == ahdlc_pkg::FLAG_BYTE) begin
          // closing flag; an empty frame in frame mode says nothing
          if (mode_q == MODE_ESC || cnt_q != '0) begin
            emit = 1'b1;
            if (mode_q == MODE_FRAME && fcs_q == ahdlc_pkg::FCS_GOOD &&
                cnt_q >= CNT_W'(2)) begin
              kind_d = ahdlc_pkg::KIND_GOOD;
              len_d  = (len_full > LW'(ahdlc_pkg::LEN_SAT)) ?
                       ahdlc_pkg::LEN_W'(ahdlc_pkg::LEN_SAT) : len_full[ahdlc_pkg::LEN_W-1:0];
            end else begin
              kind_d = ahdlc_pkg::KIND_BAD;
            end
          end
          mode_d = MODE_FRAME;
          fcs_d  = ahdlc_pkg::FCS_INIT;
          cnt_d  = '0;
          hcnt_d = '0;
        end else if (over) begin
          // overflow: drop the byte and lose sync
          emit   = 1'b1;
          kind_d = ahdlc_pkg::KIND_ABORT;
          mode_d = MODE_HUNT;
        end else begin
          mode_d = MODE_FRAME;
          fcs_d  = ahdlc_pkg::fcs_update(fcs_q, ubyte);
          cnt_d  = cnt_q + CNT_W'(1);
          if (hcnt_q >= 2'd2) begin
            emit    = 1'b1;
            data_d  = held0_q;
            held0_d = held1_q;
            held1_d = ubyte;
          end else begin
            if (hcnt_q[0]) begin
              held1_d = ubyte;
            end else begin
              held0_d = ubyte;
            end
            hcnt_d = hcnt_q + 2'd1;
          end
        end
      end
      default: begin
        mode_d = MODE_HUNT;
      end
    endcase
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HUNT;
      fcs_q  <= ahdlc_pkg::FCS_INIT;
      cnt_q  <= '0;
      hcnt_q <= '0;
    end else if (in_take) begin
      mode_q <= mode_d;
      fcs_q  <= fcs_d;
      cnt_q  <= cnt_d;
      hcnt_q <= hcnt_d;
    end
  end

  // hold line for the two newest bytes
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

  // length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= ahdlc_pkg::CFG_W'(2048);
    end else if (cfg_we_i) begin
      limit_cfg_q <= cfg_wdata_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_take && emit) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_take && emit) begin
      res_kind_q <= kind_d;
      res_data_q <= data_d;
      res_len_q  <= len_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign kind_o      = res_kind_q;
  assign data_o      = res_data_q;
  assign frame_len_o = res_len_q;

endmodule

// ----- hdl/ahdlc_checker.sv -----
// port-level checker of the hdlc receive deframer and its bind
`include "assert_macros.svh"

module ahdlc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [ahdlc_pkg::CFG_W-1:0] cfg_wdata_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [7:0]                  rx_byte_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  kind_o,
  input logic [7:0]                  data_o,
  input logic [ahdlc_pkg::LEN_W-1:0] frame_len_o
);

  // a stalled result beat stays up and unchanged
  `AHDLC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)
  `AHDLC_ASSERT(a_out_stable, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> ($stable(kind_o) && $stable(data_o) && $stable(frame_len_o)))

  // input stalls only behind a stalled result beat
  `AHDLC_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i))

  // data only on payload beats, length only on good frame ends
  `AHDLC_NEVER(a_data_zero, clk_i, rst_ni, out_valid_o && kind_o != ahdlc_pkg::KIND_PAYLOAD && data_o != 8'h00)
  `AHDLC_NEVER(a_len_zero, clk_i, rst_ni, out_valid_o && kind_o != ahdlc_pkg::KIND_GOOD && frame_len_o != '0)

endmodule

bind async_hdlc_receive_deframer_unit ahdlc_checker u_ahdlc_checker (.*);

// ----- sim/ahdlc_deframer_checker.sv -----
// checker for the hdlc receive deframer: predicts every result beat and compares it
`timescale 1ns / 100ps

module ahdlc_deframer_checker #(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ahdlc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  kind_i,
  input  logic [7:0]                  data_i,
  input  logic [ahdlc_pkg::LEN_W-1:0] frame_len_i,
  output int                          error_count_o,
  output int                          pending_o
);

  localparam int unsigned CFG_W = ahdlc_pkg::CFG_W;
  localparam int unsigned LEN_W = ahdlc_pkg::LEN_W;

  typedef enum logic [1:0] {
    HUNTING   = 2'd0,
    IN_FRAME  = 2'd1,
    AFTER_ESC = 2'd2
  } link_mode_e;

  typedef struct packed {
    ahdlc_pkg::kind_e kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } deframe_result_t;

  // shadow copy of the deframer state
  link_mode_e         mode;
  logic [15:0]        fcs_acc;
  int unsigned        taken;
  logic [7:0]         hold_line [2];
  logic [1:0]         held;
  logic [CFG_W-1:0]   limit_reg;
  deframe_result_t    expected_q [$];
  int                 errors = 0;

  assign error_count_o = errors;

  // reflected fcs-16, one data bit per step
  function automatic logic [15:0] crc16_octet(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) r = r ^ ahdlc_pkg::FCS_POLY;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic push_result(input ahdlc_pkg::kind_e k, input logic [7:0] d,
                             input logic [LEN_W-1:0] l);
    expected_q.push_back('{k, d, l});
  endtask

  task automatic open_next_frame();
    mode    = IN_FRAME;
    fcs_acc = ahdlc_pkg::FCS_INIT;
    taken   = 0;
    held    = 2'd0;
  endtask

  // one unescaped frame byte: length limit, fcs, two-deep hold line
  task automatic take_octet(input logic [7:0] b);
    int unsigned cap;
    cap = (limit_reg > MAX_FRAME) ? MAX_FRAME : limit_reg;
    if (taken >= cap) begin
      mode = HUNTING;
      push_result(ahdlc_pkg::KIND_ABORT, 8'h00, '0);
    end else begin
      fcs_acc = crc16_octet(fcs_acc, b);
      taken++;
      if (held == 2'd2) begin
        push_result(ahdlc_pkg::KIND_PAYLOAD, hold_line[0], '0);
        hold_line[0] = hold_line[1];
        hold_line[1] = b;
      end else begin
        hold_line[held[0]] = b;
        held++;
      end
      mode = IN_FRAME;
    end
  endtask

  // one raw link byte through the framing state machine
  task automatic predict_octet(input logic [7:0] b);
    int unsigned len;
    case (mode)
      HUNTING: begin
        if (b == ahdlc_pkg::FLAG_BYTE) open_next_frame();
      end
      IN_FRAME: begin
        if (b == ahdlc_pkg::ESC_BYTE) begin
          mode = AFTER_ESC;
        end else if (b == ahdlc_pkg::FLAG_BYTE) begin
          if (taken != 0) begin
            if (fcs_acc == ahdlc_pkg::FCS_GOOD && taken >= 2) begin
              len = taken - 2;
              if (len > ahdlc_pkg::LEN_SAT) len = ahdlc_pkg::LEN_SAT;
              push_result(ahdlc_pkg::KIND_GOOD, 8'h00, len[LEN_W-1:0]);
            end else begin
              push_result(ahdlc_pkg::KIND_BAD, 8'h00, '0);
            end
            open_next_frame();
          end
        end else begin
          take_octet(b);
        end
      end
      AFTER_ESC: begin
        if (b == ahdlc_pkg::FLAG_BYTE) begin
          push_result(ahdlc_pkg::KIND_BAD, 8'h00, '0);
          open_next_frame();
        end else begin
          take_octet(b ^ ahdlc_pkg::ESC_XOR);
        end
      end
      default: mode = HUNTING;
    endcase
  endtask

  // compare result beats first, then predict from the byte taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    deframe_result_t want;
    if (!rst_ni) begin
      mode      = HUNTING;
      fcs_acc   = ahdlc_pkg::FCS_INIT;
      taken     = 0;
      held      = 2'd0;
      limit_reg = CFG_W'(2048);
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat kind %0d with nothing expected", kind_i));
        end else begin
          want = expected_q.pop_front();
          if (kind_i !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind_i, want.kind));
          if (data_i !== want.data)
            report_mismatch($sformatf("data %02h, expected %02h", data_i, want.data));
          if (frame_len_i !== want.len)
            report_mismatch($sformatf("frame_len %0d, expected %0d", frame_len_i, want.len));
        end
      end
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_octet(rx_byte_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- sim/async_hdlc_receive_deframer_unit_test.sv -----
// testbench top: feeds framed, escaped and broken byte streams into the deframer and gives the verdict
`timescale 1ns / 100ps

module async_hdlc_receive_deframer_unit_test;

  localparam int unsigned CFG_W        = ahdlc_pkg::CFG_W;
  localparam int unsigned LEN_W        = ahdlc_pkg::LEN_W;
  localparam int unsigned MAX_FRAME    = 2048;
  localparam int          QUIET_LIMIT  = 3000;
  localparam int          PHASE_ITEMS  = 145;
  localparam int          HOLD_CYCLES  = 400;

  // special actions inside a random phase
  localparam int NO_EXTRA   = 0;
  localparam int RX_HOLDOFF = 1;
  localparam int TX_PAUSE   = 2;

  // idling patterns of a random phase
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       rx_byte;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       kind;
  logic [7:0]       data;
  logic [LEN_W-1:0] frame_len;
  int               errors;
  int               pending;

  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_left;
  int               items_sent;
  logic [7:0]       body_q [$];

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  async_hdlc_receive_deframer_unit #(
    .MAX_FRAME (MAX_FRAME)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .data_o      (data),
    .frame_len_o (frame_len)
  );

  ahdlc_deframer_checker #(
    .MAX_FRAME (MAX_FRAME)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .kind_i        (kind),
    .data_i        (data),
    .frame_len_i   (frame_len),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  // receiver: random stalls, or a long hold-off counted here
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [15:0] fcs_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] f;
    f = c ^ {8'h00, b};
    repeat (8) f = f[0] ? ((f >> 1) ^ ahdlc_pkg::FCS_POLY) : (f >> 1);
    return f;
  endfunction

  // payload octet biased toward the control codes and the extremes
  function automatic logic [7:0] random_octet();
    int r;
    r = $urandom_range(99);
    if (r < 8) return ahdlc_pkg::FLAG_BYTE;
    if (r < 16) return ahdlc_pkg::ESC_BYTE;
    if (r < 20) return 8'h00;
    if (r < 24) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic int pick_len();
    if ($urandom_range(99) < 5) return $urandom_range(60, 25);
    return $urandom_range(20, 0);
  endfunction

  // one raw byte beat, with optional idle cycles in front
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // control octets must be escaped, others sometimes are
  task automatic send_escaped(input logic [7:0] b);
    if (b == ahdlc_pkg::FLAG_BYTE || b == ahdlc_pkg::ESC_BYTE || $urandom_range(9) == 0) begin
      send_byte(ahdlc_pkg::ESC_BYTE);
      send_byte(b ^ ahdlc_pkg::ESC_XOR);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic fill_body(input int len);
    body_q.delete();
    repeat (len) body_q.push_back(random_octet());
  endtask

  // body_q plus fcs, escaped, then the closing flag; spoil flips one bit
  task automatic send_frame(input bit spoil);
    logic [15:0] f;
    int          pos;
    f = ahdlc_pkg::FCS_INIT;
    foreach (body_q[i]) f = fcs_next(f, body_q[i]);
    f = ~f;
    body_q.push_back(f[7:0]);
    body_q.push_back(f[15:8]);
    if (spoil) begin
      pos = $urandom_range(body_q.size() - 1);
      body_q[pos] = body_q[pos] ^ (8'h01 << $urandom_range(7));
    end
    foreach (body_q[i]) send_escaped(body_q[i]);
    send_byte(ahdlc_pkg::FLAG_BYTE);
  endtask

  // stop offering and let every expected result come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one limit setting with random traffic, mostly well-formed frames
  task automatic run_phase(input logic [CFG_W-1:0] limit, input int idle_mode, input int extra);
    int start;
    int r;
    bit done_extra;
    drain();
    write_limit(limit);
    case (idle_mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 57; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 57; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
    start      = items_sent;
    done_extra = 1'b0;
    while (items_sent - start < PHASE_ITEMS) begin
      if (!done_extra && items_sent - start > PHASE_ITEMS / 2) begin
        done_extra = 1'b1;
        if (extra == RX_HOLDOFF) hold_left = HOLD_CYCLES;
        else if (extra == TX_PAUSE) drain();
      end
      r = $urandom_range(99);
      if (r < 72) begin
        fill_body(pick_len());
        send_frame($urandom_range(99) < 15);
      end else if (r < 82) begin
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
      end else if (r < 88) begin
        send_byte(ahdlc_pkg::FLAG_BYTE);
      end else if (r < 94) begin
        send_byte(ahdlc_pkg::ESC_BYTE);
        send_byte(ahdlc_pkg::FLAG_BYTE);
      end else begin
        // frame cut short: no fcs before the flag
        fill_body(pick_len());
        foreach (body_q[i]) send_escaped(body_q[i]);
        send_byte(ahdlc_pkg::FLAG_BYTE);
      end
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    rx_byte        = 8'h00;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    rst_n          = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: bytes ignored while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ahdlc_pkg::ESC_BYTE);
    // opening flag, then an empty frame
    send_byte(ahdlc_pkg::FLAG_BYTE);
    send_byte(ahdlc_pkg::FLAG_BYTE);
    // escape followed by flag with nothing taken
    send_byte(ahdlc_pkg::ESC_BYTE);
    send_byte(ahdlc_pkg::FLAG_BYTE);
    // a single byte is too short
    send_byte(8'h55);
    send_byte(ahdlc_pkg::FLAG_BYTE);
    // fcs only: good frame of length zero
    body_q.delete();
    send_frame(1'b0);
    // control codes and an all-ones byte as payload
    body_q = '{ahdlc_pkg::FLAG_BYTE, ahdlc_pkg::ESC_BYTE, 8'hFF};
    send_frame(1'b0);
    // fcs error
    body_q = '{8'hA5};
    send_frame(1'b1);

    // random traffic over several limits
    run_phase(CFG_W'(2048), IDLE_NONE, RX_HOLDOFF);
    run_phase(CFG_W'(2),    IDLE_SEND, NO_EXTRA);
    run_phase(CFG_W'(16),   IDLE_RECV, NO_EXTRA);
    run_phase(CFG_W'(4095), IDLE_BOTH, NO_EXTRA);
    run_phase(CFG_W'(0),    IDLE_NONE, TX_PAUSE);
    run_phase(CFG_W'(1),    IDLE_SEND, NO_EXTRA);
    run_phase(CFG_W'(300),  IDLE_RECV, NO_EXTRA);
    run_phase(CFG_W'(2048), IDLE_BOTH, NO_EXTRA);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ahdlc_pkg.sv
hdl/async_hdlc_receive_deframer_unit.sv
hdl/ahdlc_checker.sv
sim/ahdlc_deframer_checker.sv
sim/async_hdlc_receive_deframer_unit_test.sv
